### hw/rtl/cab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped alpha blitter package
// Shared types, register indexes and constants for the blitter modules.
// ----------------------------------------------------------------------------
package cab_pkg;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURFACE_WIDTH  = 3'd0,
    CFG_SURFACE_HEIGHT = 3'd1,
    CFG_PLACE_X        = 3'd2,
    CFG_PLACE_Y        = 3'd3,
    CFG_RECT_WIDTH     = 3'd4,
    CFG_RECT_HEIGHT    = 3'd5,
    CFG_SOURCE_STRIDE  = 3'd6,
    CFG_BLEND_ENABLE   = 3'd7
  } cfg_reg_t;

  // Register and geometry widths.
  localparam int DIM_CFG_W = 13;
  localparam int STRIDE_W  = 16;
  localparam int GEO_W     = 16;
  localparam int CLIP_W    = GEO_W + 1;

  localparam int MAX_SURFACE_DIM_DEF = 4096;

  localparam logic [31:0] OPAQUE_ALPHA = 32'hFF00_0000;
  localparam logic [7:0]  FULL_ALPHA   = 8'd255;

  // Transaction payloads.
  typedef struct packed {
    logic [31:0] source_pixel;
    logic [31:0] surface_pixel;
  } in_item_t;

  typedef struct packed {
    logic [23:0] dest_index;
    logic [27:0] source_offset;
    logic [31:0] new_pixel;
    logic        write_enable;
    logic        region_end;
  } out_item_t;

  // Clipped region geometry derived from the configuration registers.
  typedef struct packed {
    logic                active;
    logic [GEO_W-1:0]    x0;
    logic [GEO_W-1:0]    y0;
    logic [GEO_W-1:0]    sx;
    logic [GEO_W-1:0]    sy;
    logic [GEO_W-1:0]    cw;
    logic [GEO_W-1:0]    ch;
    logic [GEO_W-1:0]    sw;
    logic [STRIDE_W-1:0] stride;
    logic                blend;
  } geom_t;

  // Position of the current pixel in surface and source coordinates.
  typedef struct packed {
    logic [GEO_W-1:0] row_abs;
    logic [GEO_W-1:0] col_abs;
    logic [GEO_W-1:0] src_row;
    logic [GEO_W-1:0] src_col;
    logic             last;
  } scan_t;

endpackage
`default_nettype wire

### hw/rtl/clipped_alpha_blitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped alpha blitter
// Walks a rectangle clipped to the surface and blends source over destination.
// ----------------------------------------------------------------------------
// An accepted transaction passes the capture, multiply and result registers before out_valid shows it.
// Throughput: one pixel per cycle; a stage advances when the next is empty or moving.
// in_ready drops for one cycle after each configuration write while the
// registered clip geometry is recomputed.
// Reset clears the configuration registers, geom.active, the scan counters and the pipeline valid bits.
// Transactions for an empty region are accepted and give no result.
module clipped_alpha_blitter import cab_pkg::*; #(
  parameter int MAX_SURFACE_DIM = MAX_SURFACE_DIM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data
);

  geom_t geom;
  scan_t pos;
  logic  settle;
  logic  s1_ready;
  logic  take;

  cab_regs #(
    .MAX_SURFACE_DIM(MAX_SURFACE_DIM)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .settle    (settle)
  );

  // Accepted transactions step the scan only when the region is not empty.
  assign in_ready = s1_ready && !settle;
  assign take     = in_valid && in_ready && geom.active;

  cab_scan #(
    .MAX_SURFACE_DIM(MAX_SURFACE_DIM)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .clear   (cfg_write),
    .advance (take),
    .pos     (pos)
  );

  cab_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_data),
    .pos       (pos),
    .geom      (geom),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // No transaction is taken while the geometry catches up with a write.
  assert property (@(posedge clk) disable iff (rst) cfg_write |=> !in_ready)
    else $error("input accepted before geometry settled");

endmodule
`default_nettype wire

### hw/rtl/cab_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Blitter configuration registers
// Holds the register file and registers the clipped region geometry.
// ----------------------------------------------------------------------------
module cab_regs import cab_pkg::*; #(
  parameter int MAX_SURFACE_DIM = MAX_SURFACE_DIM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output geom_t                     geom,
  output logic                      settle
);

  localparam logic [GEO_W-1:0] MAX_DIM = GEO_W'(MAX_SURFACE_DIM);

  logic [DIM_CFG_W-1:0] surface_width;
  logic [DIM_CFG_W-1:0] surface_height;
  logic [DIM_CFG_W-1:0] place_x;
  logic [DIM_CFG_W-1:0] place_y;
  logic [DIM_CFG_W-1:0] rect_width;
  logic [DIM_CFG_W-1:0] rect_height;
  logic [STRIDE_W-1:0]  source_stride;
  logic                 blend_enable;

  logic [GEO_W-1:0]         sw_sat, sh_sat, rw_sat, rh_sat;
  logic signed [CLIP_W-1:0] px, py, x1, y1, x1c, y1c, x0c, y0c, sxv, syv, cwv, chv;
  logic signed [CLIP_W-1:0] sw_s, sh_s, rw_s, rh_s;
  geom_t                    geom_next;

  function automatic logic [GEO_W-1:0] sat_dim(input logic [DIM_CFG_W-1:0] v);
    logic [GEO_W-1:0] w;
    w = GEO_W'(v);
    return (w > MAX_DIM) ? MAX_DIM : w;
  endfunction

  // Register writes; any write restarts the region through the scan counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= '0;
      surface_height <= '0;
      place_x        <= '0;
      place_y        <= '0;
      rect_width     <= '0;
      rect_height    <= '0;
      source_stride  <= '0;
      blend_enable   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SURFACE_WIDTH:  surface_width  <= cfg_data[DIM_CFG_W-1:0];
        CFG_SURFACE_HEIGHT: surface_height <= cfg_data[DIM_CFG_W-1:0];
        CFG_PLACE_X:        place_x        <= cfg_data[DIM_CFG_W-1:0];
        CFG_PLACE_Y:        place_y        <= cfg_data[DIM_CFG_W-1:0];
        CFG_RECT_WIDTH:     rect_width     <= cfg_data[DIM_CFG_W-1:0];
        CFG_RECT_HEIGHT:    rect_height    <= cfg_data[DIM_CFG_W-1:0];
        CFG_SOURCE_STRIDE:  source_stride  <= cfg_data[STRIDE_W-1:0];
        CFG_BLEND_ENABLE:   blend_enable   <= cfg_data[0];
        default:            blend_enable   <= blend_enable;
      endcase
    end
  end

  // Clip the placed rectangle against the surface.
  always_comb begin
    sw_sat = sat_dim(surface_width);
    sh_sat = sat_dim(surface_height);
    rw_sat = sat_dim(rect_width);
    rh_sat = sat_dim(rect_height);
    sw_s   = $signed({1'b0, sw_sat});
    sh_s   = $signed({1'b0, sh_sat});
    rw_s   = $signed({1'b0, rw_sat});
    rh_s   = $signed({1'b0, rh_sat});
    px     = $signed({{(CLIP_W-DIM_CFG_W){place_x[DIM_CFG_W-1]}}, place_x});
    py     = $signed({{(CLIP_W-DIM_CFG_W){place_y[DIM_CFG_W-1]}}, place_y});
    x1     = px + rw_s;
    y1     = py + rh_s;
    x0c    = px[CLIP_W-1] ? '0 : px;
    y0c    = py[CLIP_W-1] ? '0 : py;
    sxv    = px[CLIP_W-1] ? -px : '0;
    syv    = py[CLIP_W-1] ? -py : '0;
    x1c    = (x1 > sw_s) ? sw_s : x1;
    y1c    = (y1 > sh_s) ? sh_s : y1;
    cwv    = x1c - x0c;
    chv    = y1c - y0c;

    geom_next.active = !cwv[CLIP_W-1] && (cwv != '0) && !chv[CLIP_W-1] && (chv != '0);
    geom_next.x0     = x0c[GEO_W-1:0];
    geom_next.y0     = y0c[GEO_W-1:0];
    geom_next.sx     = sxv[GEO_W-1:0];
    geom_next.sy     = syv[GEO_W-1:0];
    geom_next.cw     = cwv[GEO_W-1:0];
    geom_next.ch     = chv[GEO_W-1:0];
    geom_next.sw     = sw_sat;
    geom_next.stride = (source_stride != '0) ? source_stride
                                             : STRIDE_W'({rw_sat, 2'b00});
    geom_next.blend  = blend_enable;
  end

  // Geometry register; settle covers the cycle in which it catches up.
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.active <= 1'b0;
      settle      <= 1'b0;
    end else begin
      geom.active <= geom_next.active;
      settle      <= cfg_write;
    end
    geom.x0     <= geom_next.x0;
    geom.y0     <= geom_next.y0;
    geom.sx     <= geom_next.sx;
    geom.sy     <= geom_next.sy;
    geom.cw     <= geom_next.cw;
    geom.ch     <= geom_next.ch;
    geom.sw     <= geom_next.sw;
    geom.stride <= geom_next.stride;
    geom.blend  <= geom_next.blend;
  end

endmodule
`default_nettype wire

### hw/rtl/cab_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Blitter region scanner
// Column and row counters that walk the clipped region in raster order.
// ----------------------------------------------------------------------------
module cab_scan import cab_pkg::*; #(
  parameter int MAX_SURFACE_DIM = MAX_SURFACE_DIM_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire geom_t geom,
  input  wire logic  clear,
  input  wire logic  advance,
  output scan_t      pos
);

  localparam int CNT_W = $clog2(MAX_SURFACE_DIM);

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [GEO_W:0]   col_inc, row_inc;
  logic             col_wrap, row_wrap;

  // Next counts and the position of the current pixel.
  always_comb begin
    col_inc     = (GEO_W+1)'(column_count) + 1'b1;
    row_inc     = (GEO_W+1)'(row_count) + 1'b1;
    col_wrap    = col_inc >= {1'b0, geom.cw};
    row_wrap    = row_inc >= {1'b0, geom.ch};
    pos.col_abs = geom.x0 + GEO_W'(column_count);
    pos.row_abs = geom.y0 + GEO_W'(row_count);
    pos.src_col = geom.sx + GEO_W'(column_count);
    pos.src_row = geom.sy + GEO_W'(row_count);
    pos.last    = col_wrap && row_wrap;
  end

  // Counters step once per accepted transaction and restart on a write.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_inc[CNT_W-1:0];
      end else begin
        column_count <= col_inc[CNT_W-1:0];
      end
    end
  end

  // The last pixel of the region brings both counters back to the start.
  assert property (@(posedge clk) disable iff (rst)
    advance && pos.last |=> column_count == '0 && row_count == '0)
    else $error("scan counters did not restart after the last pixel");

endmodule
`default_nettype wire

### hw/rtl/cab_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Blitter datapath pipeline
// Three stages: capture, multiply (addresses and channel mix), result.
// ----------------------------------------------------------------------------
module cab_pipe import cab_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire in_item_t item,
  input  wire scan_t    pos,
  input  wire geom_t    geom,
  output logic          s1_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  // Stage 1: captured transaction and position.
  logic     v1;
  in_item_t item1;
  scan_t    pos1;

  // Stage 2: products and channel sums.
  logic                        v2;
  logic [2*GEO_W-1:0]          prod_d;
  logic [GEO_W+STRIDE_W-1:0]   prod_s;
  logic [GEO_W-1:0]            col2, scol2;
  logic [2:0][15:0]            mix2, mix_next;
  logic [31:0]                 src2, dst2;
  logic                        blend2, last2;

  // Stage 3: result register.
  logic      v3;
  out_item_t out_next;

  logic r2, r3;

  // Each stage moves when the stage after it is empty or moving.
  assign r3        = !v3 || out_ready;
  assign r2        = !v2 || r3;
  assign s1_ready  = !v1 || r2;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s1_ready) v1 <= take;
      if (r2)       v2 <= v1;
      if (r3)       v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      item1 <= item;
      pos1  <= pos;
    end
  end

  // Channel products: s*a + d*(255-a).
  always_comb begin
    logic [7:0] a;
    a = item1.source_pixel[31:24];
    for (int c = 0; c < 3; c++) begin
      mix_next[c] = 16'(item1.source_pixel[8*c +: 8]) * 16'(a)
                  + 16'(item1.surface_pixel[8*c +: 8]) * 16'(FULL_ALPHA - a);
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      prod_d <= (2*GEO_W)'(pos1.row_abs) * (2*GEO_W)'(geom.sw);
      prod_s <= (GEO_W+STRIDE_W)'(pos1.src_row) * (GEO_W+STRIDE_W)'(geom.stride);
      col2   <= pos1.col_abs;
      scol2  <= pos1.src_col;
      mix2   <= mix_next;
      src2   <= item1.source_pixel;
      dst2   <= item1.surface_pixel;
      blend2 <= geom.blend;
      last2  <= pos1.last;
    end
  end

  // Final sums, division by 255 and pixel selection.
  always_comb begin
    logic [2*GEO_W-1:0]        didx_sum;
    logic [GEO_W+STRIDE_W-1:0] soff_sum;
    logic [16:0]               q;
    logic [31:0]               mixed;
    didx_sum = prod_d + (2*GEO_W)'(col2);
    soff_sum = prod_s + (GEO_W+STRIDE_W)'({scol2, 2'b00});
    mixed    = OPAQUE_ALPHA;
    // x/255 for x up to 255*255 is (x + (x >> 8) + 1) >> 8.
    for (int c = 0; c < 3; c++) begin
      q = 17'(mix2[c]) + 17'(mix2[c][15:8]) + 17'd1;
      mixed[8*c +: 8] = q[15:8];
    end
    out_next.dest_index    = didx_sum[23:0];
    out_next.source_offset = soff_sum[27:0];
    out_next.region_end    = last2;
    out_next.write_enable  = 1'b1;
    out_next.new_pixel     = src2;
    if (blend2) begin
      if (src2[31:24] == '0) begin
        out_next.write_enable = 1'b0;
        out_next.new_pixel    = dst2;
      end else if (src2[31:24] != FULL_ALPHA) begin
        out_next.new_pixel = mixed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r3) out_data <= out_next;
  end

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A transaction taken into the pipeline occupies the capture stage.
  assert property (@(posedge clk) disable iff (rst) take && s1_ready |=> v1)
    else $error("captured transaction lost");

endmodule
`default_nettype wire
